FILE: hdl/frua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frua_pkg
// Shared types, codes and sizes for the frame ring upload allocator.
// ----------------------------------------------------------------------------
package frua_pkg;

    localparam int FRAME_MARKS = 8;
    localparam int OFFSET_BITS = 32;
    localparam int POS_BITS    = OFFSET_BITS + 1;
    localparam int MARK_BITS   = (FRAME_MARKS > 1) ? $clog2(FRAME_MARKS) : 1;
    localparam int COUNT_BITS  = $clog2(FRAME_MARKS + 1);
    localparam int SUM_BITS    = POS_BITS + 2;
    localparam int QUEUE_DEPTH = 2;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_BUF_COPY  = 2'd0;
    localparam logic [1:0] FUNC_TEX_COPY  = 2'd1;
    localparam logic [1:0] FUNC_NEXT      = 2'd2;
    localparam logic [1:0] FUNC_COMPLETED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BUFFER_BYTES = 2'd0;
    localparam logic [1:0] CFG_BUF_ALIGN    = 2'd1;
    localparam logic [1:0] CFG_TEX_ALIGN    = 2'd2;
    localparam logic [1:0] CFG_FIRST_TAG    = 2'd3;

    localparam logic [31:0] RST_BUFFER_BYTES = 32'd65536;
    localparam logic [4:0]  RST_BUF_ALIGN    = 5'd0;
    localparam logic [4:0]  RST_TEX_ALIGN    = 5'd9;
    localparam logic [31:0] RST_FIRST_TAG    = 32'd0;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] request_bytes;
        logic [31:0] completed_frame;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [31:0] offset;
        logic        error;
    } t_out_item;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic        is_request;
        logic        is_next;
        logic [31:0] request_bytes;
        logic [31:0] completed_frame;
        logic [31:0] align_mask;
    } t_cmd;

endpackage

FILE: hdl/frua_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frua_front
// Takes items in, decodes the function and resolves the alignment mask.
// ----------------------------------------------------------------------------
module frua_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  frua_pkg::t_in_item i_item,
    input  logic [4:0]         i_buf_align_log2,
    input  logic [4:0]         i_tex_align_log2,
    input  logic               i_q_ready,
    output logic               o_full,
    output logic               o_push,
    output frua_pkg::t_cmd     o_cmd
);
    import frua_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic [4:0] w_lg;

    assign o_push = r_valid && i_q_ready;
    assign o_full = r_valid && !i_q_ready;
    assign o_cmd  = r_cmd;

    always_comb begin
        w_lg = (i_item.func == FUNC_TEX_COPY) ? i_tex_align_log2 : i_buf_align_log2;
        n_cmd.is_request      = (i_item.func == FUNC_BUF_COPY) ||
                                (i_item.func == FUNC_TEX_COPY);
        n_cmd.is_next         = (i_item.func == FUNC_NEXT);
        n_cmd.request_bytes   = i_item.request_bytes;
        n_cmd.completed_frame = i_item.completed_frame;
        n_cmd.align_mask      = 32'((33'd1 << w_lg) - 33'd1);
        n_valid = i_take || (r_valid && !i_q_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: hdl/frua_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frua_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module frua_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  frua_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_ready,
    output logic           o_valid,
    output frua_pkg::t_cmd o_cmd
);
    import frua_pkg::*;

    localparam int QP_BITS = $clog2(QUEUE_DEPTH);
    localparam int QC_BITS = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_slots [QUEUE_DEPTH];
    logic [QP_BITS-1:0] r_wr;
    logic [QP_BITS-1:0] r_rd;
    logic [QC_BITS-1:0] r_count;
    logic [QP_BITS-1:0] n_wr;
    logic [QP_BITS-1:0] n_rd;
    logic [QC_BITS-1:0] n_count;
    logic               w_pop;

    assign o_ready = (r_count != QC_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slots[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QP_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == QP_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/frua_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frua_back
// Carries out commands: ring placement, frame mark push and pop.
// ----------------------------------------------------------------------------
module frua_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  frua_pkg::t_cmd      i_cmd,
    input  logic [31:0]         i_buffer_bytes,
    output logic                o_done,
    output frua_pkg::t_out_item o_result
);
    import frua_pkg::*;

    logic [POS_BITS-1:0]   r_head;
    logic [POS_BITS-1:0]   r_tail;
    logic [31:0]           r_frame;
    logic [31:0]           r_mark_tag [FRAME_MARKS];
    logic [POS_BITS-1:0]   r_mark_pos [FRAME_MARKS];
    logic [MARK_BITS-1:0]  r_rd_ptr;
    logic [MARK_BITS-1:0]  r_wr_ptr;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_done;
    t_out_item             r_result;

    logic [POS_BITS-1:0]   n_head;
    logic [POS_BITS-1:0]   n_tail;
    logic [31:0]           n_frame;
    logic [MARK_BITS-1:0]  n_rd_ptr;
    logic [MARK_BITS-1:0]  n_wr_ptr;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_mark_we;
    t_out_item             n_result;

    logic [SUM_BITS-1:0]   w_mask;
    logic [SUM_BITS-1:0]   w_aligned;
    logic [SUM_BITS-1:0]   w_end;
    logic                  w_fit_up;
    logic                  w_fit_wrap;
    logic                  w_fit_below;
    logic                  w_is_completed;

    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        w_mask      = SUM_BITS'(i_cmd.align_mask);
        w_aligned   = (SUM_BITS'(r_tail) + w_mask) & ~w_mask;
        w_end       = w_aligned + SUM_BITS'(i_cmd.request_bytes);
        w_fit_up    = (w_end <= SUM_BITS'(i_buffer_bytes));
        w_fit_wrap  = (POS_BITS'(i_cmd.request_bytes) < r_head);
        w_fit_below = (w_end < SUM_BITS'(r_head));
        w_is_completed = !i_cmd.is_request && !i_cmd.is_next;

        n_head    = r_head;
        n_tail    = r_tail;
        n_frame   = r_frame;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_mark_we = 1'b0;
        n_result  = '0;

        if (i_cmd.is_request) begin
            if (r_tail >= r_head) begin
                if (w_fit_up) begin
                    n_result.granted = 1'b1;
                    n_result.offset  = w_aligned[31:0];
                    n_tail           = w_end[POS_BITS-1:0];
                end else if (w_fit_wrap) begin
                    // Wrap: placed unaligned at the start of the buffer.
                    n_result.granted = 1'b1;
                    n_tail           = POS_BITS'(i_cmd.request_bytes);
                end else begin
                    n_result.error = 1'b1;
                end
            end else if (w_fit_below) begin
                n_result.granted = 1'b1;
                n_result.offset  = w_aligned[31:0];
                n_tail           = w_end[POS_BITS-1:0];
            end else begin
                n_result.error = 1'b1;
            end
        end else if (i_cmd.is_next) begin
            if (r_count >= COUNT_BITS'(FRAME_MARKS)) begin
                n_result.error = 1'b1;
            end else begin
                n_mark_we = 1'b1;
                n_wr_ptr  = (r_wr_ptr == MARK_BITS'(FRAME_MARKS - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
                n_count   = r_count + 1'b1;
                n_frame   = r_frame + 32'd1;
            end
        end else if (w_is_completed) begin
            if (r_count == '0 || r_mark_tag[r_rd_ptr] != i_cmd.completed_frame) begin
                n_result.error = 1'b1;
            end else begin
                n_head   = r_mark_pos[r_rd_ptr];
                n_rd_ptr = (r_rd_ptr == MARK_BITS'(FRAME_MARKS - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_frame  <= RST_FIRST_TAG;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_valid;
            if (i_valid) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_frame  <= n_frame;
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
                r_count  <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
            if (n_mark_we) begin
                r_mark_tag[r_wr_ptr] <= r_frame;
                r_mark_pos[r_wr_ptr] <= r_tail;
            end
        end
    end

endmodule

FILE: hdl/frame_ring_upload_allocator_core.sv
`timescale 1ns / 1ps
// A result strobes on o_done after the front, queue and back end registers.
// Throughput: one item per cycle; the back end finishes a command every cycle.
// The receiver cannot stall, so busy only rises if the command queue fills.
// Reset (synchronous, active low) empties the ring and the frame mark FIFO,
// restores the configuration defaults and sets the frame tag to its default.
// ----------------------------------------------------------------------------
// frame_ring_upload_allocator_core
// Ring allocator over an upload buffer with frame fences: front decode,
// command queue and back end that owns head, tail and the frame marks.
// ----------------------------------------------------------------------------
module frame_ring_upload_allocator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  frua_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata,
    output logic                o_done,
    output frua_pkg::t_out_item o_result
);
    import frua_pkg::*;

    logic [31:0] r_buffer_bytes;
    logic [4:0]  r_buf_align_log2;
    logic [4:0]  r_tex_align_log2;

    logic        w_take;
    logic        w_push;
    logic        w_q_ready;
    logic        w_q_valid;
    t_cmd        w_front_cmd;
    t_cmd        w_back_cmd;

    assign w_take = start && !busy;

    // The first frame tag only matters at reset, where it returns to its
    // default, so a write to it needs no storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes   <= RST_BUFFER_BYTES;
            r_buf_align_log2 <= RST_BUF_ALIGN;
            r_tex_align_log2 <= RST_TEX_ALIGN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUFFER_BYTES: r_buffer_bytes   <= i_cfg_wdata;
                CFG_BUF_ALIGN:    r_buf_align_log2 <= i_cfg_wdata[4:0];
                CFG_TEX_ALIGN:    r_tex_align_log2 <= i_cfg_wdata[4:0];
                CFG_FIRST_TAG:    ;
                default:          ;
            endcase
        end
    end

    frua_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (w_take),
        .i_item           (i_item),
        .i_buf_align_log2 (r_buf_align_log2),
        .i_tex_align_log2 (r_tex_align_log2),
        .i_q_ready        (w_q_ready),
        .o_full           (busy),
        .o_push           (w_push),
        .o_cmd            (w_front_cmd)
    );

    frua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_q_valid),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd)
    );

    frua_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_cmd          (w_back_cmd),
        .i_buffer_bytes (r_buffer_bytes),
        .o_done         (o_done),
        .o_result       (o_result)
    );

endmodule

FILE: bench/frua_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frua_ring_checker
// Watches the command, result and register channels of the frame ring upload
// allocator, predicts every result from its own copy of head, tail and frame
// marks, and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module frua_ring_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  frua_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_done,
    input  frua_pkg::t_out_item i_result,
    output int                  o_mismatches,
    output int                  o_outstanding
);
    import frua_pkg::*;

    localparam logic [63:0] POS_MASK = (64'd1 << POS_BITS) - 64'd1;

    typedef struct {
        logic [31:0] tag;
        logic [63:0] pos;
    } t_frame_mark;

    // Configuration as the block should see it.
    logic [31:0] ring_size;
    logic [4:0]  buf_align_lg;
    logic [4:0]  tex_align_lg;

    // Allocator state.
    logic [63:0] head_pos;
    logic [63:0] tail_pos;
    logic [31:0] frame_tag_now;
    t_frame_mark open_frames[$];

    t_out_item   results_due[$];
    t_out_item   due;
    int          errors_seen = 0;

    // Applies one command to the allocator state and returns its result.
    function automatic t_out_item ring_outcome(input t_in_item it);
        t_out_item   r;
        t_frame_mark m;
        logic [4:0]  lg;
        logic [63:0] algn;
        logic [63:0] aligned;
        logic [63:0] need;
        logic [63:0] req;
        logic [63:0] new_tail;
        logic        fits;
        r = '0;
        case (it.func)
            FUNC_BUF_COPY, FUNC_TEX_COPY: begin
                lg       = (it.func == FUNC_BUF_COPY) ? buf_align_lg : tex_align_lg;
                algn     = 64'd1 << lg;
                aligned  = (tail_pos + algn - 64'd1) & ~(algn - 64'd1);
                req      = {32'd0, it.request_bytes};
                need     = aligned - tail_pos + req;
                fits     = 1'b0;
                new_tail = '0;
                if (tail_pos >= head_pos) begin
                    if (tail_pos + need <= {32'd0, ring_size}) begin
                        fits     = 1'b1;
                        r.offset = aligned[31:0];
                        new_tail = tail_pos + need;
                    end else if (req < head_pos) begin
                        // Does not fit at the end: wrap to the start, unaligned.
                        fits     = 1'b1;
                        r.offset = '0;
                        new_tail = req;
                    end
                end else if (tail_pos + need < head_pos) begin
                    fits     = 1'b1;
                    r.offset = aligned[31:0];
                    new_tail = tail_pos + need;
                end
                if (fits) begin
                    r.granted = 1'b1;
                    tail_pos  = new_tail & POS_MASK;
                end else begin
                    r.error  = 1'b1;
                    r.offset = '0;
                end
            end
            FUNC_NEXT: begin
                if (open_frames.size() >= FRAME_MARKS) begin
                    r.error = 1'b1;
                end else begin
                    m.tag = frame_tag_now;
                    m.pos = tail_pos;
                    open_frames.push_back(m);
                    frame_tag_now = frame_tag_now + 32'd1;
                end
            end
            default: begin
                if (open_frames.size() == 0 || open_frames[0].tag != it.completed_frame) begin
                    r.error = 1'b1;
                end else begin
                    head_pos = open_frames[0].pos & POS_MASK;
                    void'(open_frames.pop_front());
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors_seen++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_size     = RST_BUFFER_BYTES;
            buf_align_lg  = RST_BUF_ALIGN;
            tex_align_lg  = RST_TEX_ALIGN;
            head_pos      = '0;
            tail_pos      = '0;
            frame_tag_now = RST_FIRST_TAG;
            open_frames.delete();
            results_due.delete();
        end else begin
            if (i_done) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with no result due: granted %b offset %h error %b",
                           i_result.granted, i_result.offset, i_result.error);
                    errors_seen++;
                end else begin
                    due = results_due.pop_front();
                    check_field("granted", {31'd0, due.granted}, {31'd0, i_result.granted});
                    check_field("offset", due.offset, i_result.offset);
                    check_field("error", {31'd0, due.error}, {31'd0, i_result.error});
                end
            end
            if (i_start && !i_busy) begin
                results_due.push_back(ring_outcome(i_item));
            end
            // A register write counts from the next command on. The first
            // frame tag goes back to its default at reset, so its write
            // changes nothing here.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUFFER_BYTES: ring_size    = i_cfg_wdata;
                    CFG_BUF_ALIGN:    buf_align_lg = i_cfg_wdata[4:0];
                    CFG_TEX_ALIGN:    tex_align_lg = i_cfg_wdata[4:0];
                    default:          ;
                endcase
            end
        end
        o_outstanding <= results_due.size();
        o_mismatches  <= errors_seen;
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the allocator bench: drives directed and random commands and
// register settings into the core, lets the checker judge every result, and
// prints the verdict.
// ----------------------------------------------------------------------------
module tb;
    import frua_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_BUFFER_BYTES;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_done;
    t_out_item   o_result;

    int          mismatches;
    int          outstanding;

    // Stimulus bookkeeping: frames pushed and not yet retired, used to build
    // completions that carry the right tag.
    int          idle_pct = 0;
    int          frames_open = 0;
    logic [31:0] next_tag = RST_FIRST_TAG;
    logic [31:0] ring_bytes = RST_BUFFER_BYTES;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    frame_ring_upload_allocator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    frua_ring_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_done        (o_done),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic logic [31:0] oldest_tag();
        return next_tag - 32'(frames_open);
    endfunction

    task automatic issue(input logic [1:0] f, input logic [31:0] bytes, input logic [31:0] tag);
        t_in_item it;
        it.func            = f;
        it.request_bytes   = bytes;
        it.completed_frame = tag;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (f == FUNC_NEXT && frames_open < FRAME_MARKS) begin
            frames_open++;
            next_tag = next_tag + 32'd1;
        end else if (f == FUNC_COMPLETED && frames_open > 0 && tag == oldest_tag()) begin
            frames_open--;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int          pick;
        logic [1:0]  f;
        logic [31:0] bytes;
        logic [31:0] tag;
        pick  = $urandom_range(0, 99);
        bytes = $urandom;
        tag   = $urandom;
        if (pick < 55) begin
            f = $urandom_range(0, 1) ? FUNC_TEX_COPY : FUNC_BUF_COPY;
            case ($urandom_range(0, 9))
                0: bytes = '0;
                1: bytes = $urandom;
                default: bytes = $urandom_range(0, ring_bytes / 4);
            endcase
        end else if (pick < 75) begin
            f = FUNC_NEXT;
        end else begin
            f = FUNC_COMPLETED;
            // Mostly the right tag, so frames keep retiring and the ring turns.
            if (pick < 94) begin
                tag = oldest_tag();
            end else if (pick < 97) begin
                tag = oldest_tag() + 32'd1;
            end
        end
        issue(f, bytes, tag);
    endtask

    task automatic run_phase(input logic [31:0] bytes, input logic [4:0] lg_buf,
                             input logic [4:0] lg_tex, input logic [31:0] tag0,
                             input int count, input int gap_pct);
        drain();
        write_reg(CFG_BUFFER_BYTES, bytes);
        write_reg(CFG_BUF_ALIGN, {27'd0, lg_buf});
        write_reg(CFG_TEX_ALIGN, {27'd0, lg_tex});
        write_reg(CFG_FIRST_TAG, tag0);
        i_cfg_we   <= 1'b0;
        ring_bytes = bytes;
        idle_pct   = gap_pct;
        repeat (count) random_item();
    endtask

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset configuration.
        issue(FUNC_COMPLETED, 32'd0, 32'd0);          // nothing pushed yet
        issue(FUNC_BUF_COPY, 32'd3, '0);
        issue(FUNC_TEX_COPY, 32'd1, '0);              // aligned up past the tail
        issue(FUNC_BUF_COPY, 32'd0, '0);
        issue(FUNC_BUF_COPY, 32'hFFFF_FFFF, '1);      // can never fit
        repeat (FRAME_MARKS + 1) issue(FUNC_NEXT, '0, '0);  // last push finds the marks full
        issue(FUNC_COMPLETED, '0, 32'hFFFF_FFFF);     // wrong tag
        issue(FUNC_COMPLETED, '0, oldest_tag());
        issue(FUNC_BUF_COPY, 32'd65023, '0);          // fills up to the very end
        issue(FUNC_BUF_COPY, 32'd100, '0);            // wraps to offset zero
        issue(FUNC_BUF_COPY, 32'd500, '0);            // would run into the head
        issue(FUNC_BUF_COPY, 32'd412, '0);            // stops one byte short of the head
        issue(FUNC_BUF_COPY, 32'd1, '0);
        issue(FUNC_TEX_COPY, 32'd0, '0);

        run_phase(32'd4096, 5'd0, 5'd4, 32'hFFFF_FFFF, 500, 0);
        run_phase(32'd0, 5'd31, 5'd17, 32'd0, 40, 74);
        run_phase(32'hFFFF_FFFF, 5'd16, 5'd31, $urandom, 250, 74);
        run_phase(32'd1, 5'd0, 5'd0, $urandom, 60, 27);
        run_phase(32'd300, 5'd3, 5'd5, $urandom, 450, 27);
        run_phase(RST_BUFFER_BYTES, RST_BUF_ALIGN, RST_TEX_ALIGN, RST_FIRST_TAG, 550, 0);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
